@@ rtl/core/b2da_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   // default width of the unsigned input value
   localparam int DEF_VALUE_BITS = 32;

   // double-dabble steps handled per pipeline stage, at most
   localparam int MAX_STEPS_PER_STAGE = 8;

   // fewest register stages in the conversion pipeline
   localparam int MIN_STAGES = 3;

   // ASCII character codes, trimmed to the 6-bit result field
   localparam logic [5:0] ASCII_ZERO = 6'd48;
   localparam logic [5:0] ASCII_NINE = 6'd57;

   // BCD digit at or above this value gets the +3 correction before a shift
   localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

endpackage

@@ rtl/core/binary_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned number to its decimal ASCII digits, most significant
// first, no leading zeros, with tlast on the final digit.
// ----------------------------------------------------------------------------
// Pipeline: NumStages double-dabble stages (four at VALUE_BITS = 32, of 8
//    steps each), then the output serializer, which offers the digits.
// Throughput: one digit per cycle while rsp_tready is high; a number with D
//    digits (1 to 10 at 32 bits) holds the output serializer until its D digits
//    are taken, and the pipeline takes a new item every cycle as long as the serializer drains.
// Reset: synchronous, clears all valid bits and the serializer's busy flag; payload and digit index hold.
module binary_to_decimal_ascii
   import b2da_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_BITS + 7) / 8)*8-1:0] req_tdata,  // [VALUE_BITS-1:0] value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [5:0] digit_char
   output logic                                rsp_tlast   // last_digit
);

   // digits of 2^VALUE_BITS - 1: floor(VALUE_BITS * log10(2)) + 1
   localparam int NumDigits = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BcdW      = 4 * NumDigits;
   localparam int IdxW      = $clog2(NumDigits);
   localparam int RawStages = (VALUE_BITS + MAX_STEPS_PER_STAGE - 1) / MAX_STEPS_PER_STAGE;
   localparam int NumStages = (RawStages < MIN_STAGES) ? MIN_STAGES : RawStages;
   localparam int StepsPerStage = (VALUE_BITS + NumStages - 1) / NumStages;
   // zero padding on top keeps every stage at the same step count
   localparam int TotalBits = NumStages * StepsPerStage;
   localparam int Last      = NumStages - 1;

   typedef struct packed {
      logic [BcdW-1:0]      bcd;
      logic [TotalBits-1:0] bin;
   } stage_type;

   function automatic stage_type dabble_chunk(input stage_type s);
      stage_type t;
      t = s;
      for (int st = 0; st < StepsPerStage; st++) begin
         for (int dg = 0; dg < NumDigits; dg++) begin
            if (t.bcd[4*dg +: 4] >= BCD_ADJ_LIMIT) begin
               t.bcd[4*dg +: 4] = t.bcd[4*dg +: 4] + BCD_ADJ_ADD;
            end
         end
         {t.bcd, t.bin} = {t.bcd[BcdW-2:0], t.bin, 1'b0};
      end
      return t;
   endfunction

   // conversion pipeline
   stage_type              stage_ff [NumStages];
   stage_type              stage_in [NumStages];
   logic [NumStages-1:0]   vld_ff;
   logic [NumStages-1:0]   vld_in;
   logic [NumStages-1:0]   adv;
   stage_type              first_src;

   // output serializer
   logic [BcdW-1:0]        ser_bcd_ff;
   logic [BcdW-1:0]        ser_bcd_in;
   logic [IdxW-1:0]        idx_ff;
   logic [IdxW-1:0]        idx_in;
   logic                   busy_ff;
   logic                   busy_in;
   logic                   load;
   logic [IdxW-1:0]        top_idx;
   logic [3:0]             cur_digit;

   always_comb begin
      first_src.bcd = '0;
      first_src.bin = TotalBits'(req_tdata[VALUE_BITS-1:0]);
      stage_in[0] = dabble_chunk(first_src);
      for (int k = 1; k < NumStages; k++) begin
         stage_in[k] = dabble_chunk(stage_ff[k-1]);
      end
   end

   // serializer takes a new number when empty or on the final digit's handshake
   assign load = !busy_ff || (rsp_tready && (idx_ff == '0));

   always_comb begin
      adv[Last] = !vld_ff[Last] || load;
      for (int k = Last - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = vld_ff;
      for (int k = 0; k < NumStages; k++) begin
         if (adv[k]) begin
            vld_in[k] = (k == 0) ? req_tvalid : vld_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign req_tready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NumStages; k++) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // position of the most significant nonzero digit, zero for a zero value
   always_comb begin
      top_idx = '0;
      for (int k = 1; k < NumDigits; k++) begin
         if (stage_ff[Last].bcd[4*k +: 4] != 4'd0) begin
            top_idx = IdxW'(k);
         end
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      ser_bcd_in = ser_bcd_ff;
      if (load) begin
         busy_in    = vld_ff[Last];
         idx_in     = top_idx;
         ser_bcd_in = stage_ff[Last].bcd;
      end else if (rsp_tready) begin
         // advance to the next lower digit
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      ser_bcd_ff <= ser_bcd_in;
   end

   assign cur_digit  = ser_bcd_ff[4*idx_ff +: 4];
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {2'b00, ASCII_ZERO + 6'(cur_digit)};
   assign rsp_tlast  = (idx_ff == '0);

   // every emitted character is a decimal digit
   a_digit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:0] >= ASCII_ZERO && rsp_tdata[5:0] <= ASCII_NINE))
      else $error("digit character out of range");

   // a number does not end before its final digit is taken
   a_more_digits : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("digit run cut short");

   // a blocked final stage keeps its item
   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      vld_ff[Last] && !load |=> vld_ff[Last] && $stable(stage_ff[Last].bcd))
      else $error("final stage lost its item");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_to_decimal_ascii. A short table of directed
// numbers runs first, then random numbers spread over every digit count.
// Each accepted number is turned into its expected ASCII digits, most
// significant first with tlast on the final digit, and every digit that
// leaves the block is checked in order. Both sides idle at random, and the
// receiver holds off once for long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
   import b2da_pkg::*;

   localparam int RADIX         = 10;
   localparam int RANDOM_ITEMS  = 250;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 60;
   localparam int DRAIN_CYCLES  = 20;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DIR_COUNT     = 18;

   typedef struct packed {
      logic [5:0] digit_char;
      logic       last_digit;
   } digit_t;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [5:0] digit_char
   logic        rsp_tlast;         // last_digit

   digit_t      pending_digits [$];
   int unsigned fail_count   = 0;
   int unsigned digits_seen  = 0;
   int unsigned numbers_sent = 0;
   int unsigned hold_left    = 0;
   bit          hold_done    = 1'b0;
   bit          steady       = 1'b0;

   // a row with text carries its expected digits; an empty text uses the predictor
   logic [31:0] dir_value [DIR_COUNT] = '{
      32'd0, 32'd0, 32'd1, 32'd9, 32'd10, 32'd4294967295,
      32'd99, 32'd100, 32'd999999999, 32'd1000000000, 32'd4294967294,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
      32'd12345, 32'd4000000000, 32'd1000000001
   };
   string dir_text [DIR_COUNT] = '{
      "0", "0", "1", "9", "10", "4294967295",
      "", "", "", "", "", "", "", "", "", "", "", ""
   };

   binary_to_decimal_ascii u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // peel digits off by remainder, then queue them most significant first
   function automatic void queue_decimal_digits(input logic [31:0] value);
      logic [31:0] rest;
      logic [3:0]  found [$];
      rest = value;
      do begin
         found.push_back(4'(rest % RADIX));
         rest = rest / RADIX;
      end while (rest != 0);
      for (int k = found.size() - 1; k >= 0; k--) begin
         pending_digits.push_back('{ASCII_ZERO + 6'(found[k]), k == 0});
      end
   endfunction

   function automatic void queue_text_digits(input string text);
      for (int k = 0; k < text.len(); k++) begin
         pending_digits.push_back('{6'(text[k]), k == text.len() - 1});
      end
   endfunction

   function automatic logic [31:0] random_value();
      int unsigned pick;
      int unsigned scale;
      logic [31:0] pow;
      pick  = $urandom_range(0, 3);
      scale = $urandom_range(1, 9);
      pow   = 32'd1;
      repeat (scale) pow = pow * RADIX;
      case (pick)
         0: return $urandom;
         1: return $urandom >> $urandom_range(0, 31);
         // land on either side of a digit-count boundary
         2: return pow + $urandom_range(0, 2) - 1;
         default: return $urandom_range(0, 99);
      endcase
   endfunction

   task automatic send_number(input logic [31:0] value, input string text);
      while (!steady && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      numbers_sent++;
      if (text != "") begin
         queue_text_digits(text);
      end else begin
         queue_decimal_digits(value);
      end
   endtask

   // digit checker and receiver pacing
   initial begin
      digit_t want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            digits_seen++;
            if (pending_digits.size() == 0) begin
               $error("unexpected digit: tdata %0d, tlast %0d", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = pending_digits.pop_front();
               if (rsp_tdata !== {2'b00, want.digit_char}) begin
                  $error("digit_char: expected %0d, got %0d", want.digit_char, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last_digit) begin
                  $error("last_digit: expected %0d, got %0d", want.last_digit, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (!hold_done && digits_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || $urandom_range(0, 99) >= 14;
         end
      end
   end

   // end the run when nothing moves on either side for too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIR_COUNT; i++) begin
         send_number(dir_value[i], dir_text[i]);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // no idling on either side through this stretch
         steady = (i >= 120 && i < 180);
         send_number(random_value(), "");
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d numbers converted (%0d from the directed table), %0d digits checked",
               numbers_sent, DIR_COUNT, digits_seen);
      $display("summary: random idling, one %0d-cycle receiver hold-off, %0d mismatches",
               HOLD_CYCLES, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
